>>> rtl/srtcp_pkg.sv
// ----------------------------------------------------------------------------
// srtcp_pkg
// shared types, character codes and weight tables for the srt cue parser
// ----------------------------------------------------------------------------
package srtcp_pkg;

  // character codes
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // positions inside HH:MM:SS,mmm
  localparam logic [3:0] POS_COLON_HM = 4'd2;
  localparam logic [3:0] POS_COLON_MS = 4'd5;
  localparam logic [3:0] POS_COMMA    = 4'd8;
  localparam logic [3:0] POS_FRAC     = 4'd9;
  localparam logic [3:0] POS_END      = 4'd12;

  // length of the " --> " separator
  localparam logic [2:0] ARROW_LEN = 3'd5;

  // result queue depth (one item makes at most two results)
  localparam int QDEPTH = 3;

  typedef enum logic [1:0] {
    PH_NUMBER,
    PH_START,
    PH_END,
    PH_TEXT
  } phase_t;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_HEADER  = 2'd0;
  localparam kind_t KIND_TEXT    = 2'd1;
  localparam kind_t KIND_CUE_END = 2'd2;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] cue_index;
    logic [31:0] cue_number;
    logic [28:0] start_ms;
    logic [28:0] end_ms;
    logic        start_bad;
    logic        end_bad;
    logic [7:0]  text_byte;
    logic        last_of_run;
  } result_t;

  // non-digit bytes count as zero
  function automatic logic [3:0] digit_of(input logic [7:0] b);
    logic [7:0] d;
    d = b - CHAR_ZERO;
    return (b >= CHAR_ZERO && b <= CHAR_NINE) ? d[3:0] : 4'd0;
  endfunction

  // millisecond weight of a digit in the hours, minutes, seconds part
  function automatic logic [25:0] hms_weight(input logic [3:0] pos);
    logic [25:0] w;
    unique case (pos)
      4'd0:    w = 26'd36000000;
      4'd1:    w = 26'd3600000;
      4'd3:    w = 26'd600000;
      4'd4:    w = 26'd60000;
      4'd6:    w = 26'd10000;
      4'd7:    w = 26'd1000;
      default: w = 26'd0;
    endcase
    return w;
  endfunction

  // weight of a digit in the milliseconds part
  function automatic logic [6:0] frac_weight(input logic [3:0] pos);
    logic [6:0] w;
    unique case (pos)
      4'd9:    w = 7'd100;
      4'd10:   w = 7'd10;
      4'd11:   w = 7'd1;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

  // expected byte of " --> " at a match position
  function automatic logic [7:0] arrow_byte(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = CHAR_SPACE;
      3'd1:    c = CHAR_DASH;
      3'd2:    c = CHAR_DASH;
      3'd3:    c = CHAR_GT;
      3'd4:    c = CHAR_SPACE;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/srtcp_parse.sv
// ----------------------------------------------------------------------------
// srtcp_parse
// parse state and single-pass update for one byte, up to two results out
// ----------------------------------------------------------------------------
module srtcp_parse (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         byte_value,
  input  logic               final_byte,
  output logic [1:0]         res_cnt,
  output srtcp_pkg::result_t res0,
  output srtcp_pkg::result_t res1
);

  srtcp_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] number_acc_r, number_acc_nxt;
  logic [3:0]  char_pos_r, char_pos_nxt;
  logic [9:0]  subfield_acc_r, subfield_acc_nxt;
  logic [28:0] time_acc_r, time_acc_nxt;
  logic        time_bad_r, time_bad_nxt;
  logic [28:0] saved_start_ms_r, saved_start_ms_nxt;
  logic        saved_start_bad_r, saved_start_bad_nxt;
  logic [2:0]  arrow_match_r, arrow_match_nxt;
  logic        pending_lf_r, pending_lf_nxt;
  logic [15:0] cues_done_r, cues_done_nxt;

  logic [3:0]  digit;
  logic [29:0] hms_prod;
  logic [10:0] frac_prod;
  logic [3:0]  f_pos;
  logic [9:0]  f_sub;
  logic [28:0] f_acc;
  logic        f_bad;
  logic        fin_bad;
  logic [28:0] fin_ms;
  logic [2:0]  arrow_inc;
  logic        is_lf;
  srtcp_pkg::result_t blank;

  assign digit     = srtcp_pkg::digit_of(byte_value);
  assign hms_prod  = 30'(digit) * 30'(srtcp_pkg::hms_weight(char_pos_r));
  assign frac_prod = 11'(digit) * 11'(srtcp_pkg::frac_weight(char_pos_r));
  assign is_lf     = (byte_value == srtcp_pkg::CHAR_LF);
  assign arrow_inc = arrow_match_r + 3'd1;

  // one time byte consumed at the current position
  always_comb begin
    f_pos = char_pos_r;
    f_sub = subfield_acc_r;
    f_acc = time_acc_r;
    f_bad = time_bad_r;
    if (char_pos_r < srtcp_pkg::POS_END) begin
      f_pos = char_pos_r + 4'd1;
      if (char_pos_r == srtcp_pkg::POS_COLON_HM || char_pos_r == srtcp_pkg::POS_COLON_MS) begin
        if (byte_value != srtcp_pkg::CHAR_COLON) f_bad = 1'b1;
      end else if (char_pos_r == srtcp_pkg::POS_COMMA) begin
        if (byte_value != srtcp_pkg::CHAR_COMMA) f_bad = 1'b1;
      end else if (char_pos_r >= srtcp_pkg::POS_FRAC) begin
        f_sub = subfield_acc_r + frac_prod[9:0];
      end else begin
        f_acc = time_acc_r + hms_prod[28:0];
      end
    end
    // comma never reached also marks the time bad
    fin_bad = f_bad || (f_pos < srtcp_pkg::POS_FRAC);
    fin_ms  = fin_bad ? 29'd0 : (f_acc + 29'(f_sub));
  end

  always_comb begin
    phase_nxt           = phase_r;
    number_acc_nxt      = number_acc_r;
    char_pos_nxt        = char_pos_r;
    subfield_acc_nxt    = subfield_acc_r;
    time_acc_nxt        = time_acc_r;
    time_bad_nxt        = time_bad_r;
    saved_start_ms_nxt  = saved_start_ms_r;
    saved_start_bad_nxt = saved_start_bad_r;
    arrow_match_nxt     = arrow_match_r;
    pending_lf_nxt      = pending_lf_r;
    cues_done_nxt       = cues_done_r;

    blank             = '0;
    blank.kind        = srtcp_pkg::KIND_TEXT;
    blank.cue_index   = cues_done_r;
    blank.cue_number  = number_acc_r;
    res_cnt           = 2'd0;
    res0              = blank;
    res1              = blank;

    unique case (phase_r)
      srtcp_pkg::PH_NUMBER: begin
        if (is_lf) begin
          phase_nxt        = srtcp_pkg::PH_START;
          char_pos_nxt     = '0;
          subfield_acc_nxt = '0;
          time_acc_nxt     = '0;
          time_bad_nxt     = 1'b0;
          arrow_match_nxt  = '0;
        end else begin
          number_acc_nxt = (number_acc_r << 3) + (number_acc_r << 1) + 32'(digit);
        end
      end
      srtcp_pkg::PH_START: begin
        char_pos_nxt     = f_pos;
        subfield_acc_nxt = f_sub;
        time_acc_nxt     = f_acc;
        time_bad_nxt     = f_bad;
        if (arrow_match_r < srtcp_pkg::ARROW_LEN &&
            byte_value == srtcp_pkg::arrow_byte(arrow_match_r)) begin
          if (arrow_inc == srtcp_pkg::ARROW_LEN) begin
            saved_start_ms_nxt  = fin_ms;
            saved_start_bad_nxt = fin_bad;
            char_pos_nxt        = '0;
            subfield_acc_nxt    = '0;
            time_acc_nxt        = '0;
            time_bad_nxt        = 1'b0;
            arrow_match_nxt     = '0;
            phase_nxt           = srtcp_pkg::PH_END;
          end else begin
            arrow_match_nxt = arrow_inc;
          end
        end else begin
          arrow_match_nxt = (byte_value == srtcp_pkg::CHAR_SPACE) ? 3'd1 : 3'd0;
        end
      end
      srtcp_pkg::PH_END: begin
        char_pos_nxt     = f_pos;
        subfield_acc_nxt = f_sub;
        time_acc_nxt     = f_acc;
        time_bad_nxt     = f_bad;
        if (is_lf) begin
          res_cnt          = 2'd1;
          res0.kind        = srtcp_pkg::KIND_HEADER;
          res0.start_ms    = saved_start_ms_r;
          res0.start_bad   = saved_start_bad_r;
          res0.end_ms      = fin_ms;
          res0.end_bad     = fin_bad;
          char_pos_nxt     = '0;
          subfield_acc_nxt = '0;
          time_acc_nxt     = '0;
          time_bad_nxt     = 1'b0;
          pending_lf_nxt   = 1'b0;
          phase_nxt        = srtcp_pkg::PH_TEXT;
        end
      end
      srtcp_pkg::PH_TEXT: begin
        if (is_lf) begin
          if (pending_lf_r) begin
            // blank line closes the cue
            res_cnt             = 2'd1;
            res0.kind           = srtcp_pkg::KIND_CUE_END;
            cues_done_nxt       = cues_done_r + 16'd1;
            phase_nxt           = srtcp_pkg::PH_NUMBER;
            number_acc_nxt      = '0;
            char_pos_nxt        = '0;
            subfield_acc_nxt    = '0;
            time_acc_nxt        = '0;
            time_bad_nxt        = 1'b0;
            saved_start_ms_nxt  = '0;
            saved_start_bad_nxt = 1'b0;
            arrow_match_nxt     = '0;
            pending_lf_nxt      = 1'b0;
          end else begin
            pending_lf_nxt = 1'b1;
          end
        end else if (pending_lf_r) begin
          // held line break goes out ahead of this byte
          res_cnt         = 2'd2;
          res0.text_byte  = srtcp_pkg::CHAR_LF;
          res1.text_byte  = byte_value;
          pending_lf_nxt  = 1'b0;
        end else begin
          res_cnt        = 2'd1;
          res0.text_byte = byte_value;
        end
      end
      default: ;
    endcase

    // last byte of the file drops any unfinished cue
    if (final_byte) begin
      phase_nxt           = srtcp_pkg::PH_NUMBER;
      number_acc_nxt      = '0;
      char_pos_nxt        = '0;
      subfield_acc_nxt    = '0;
      time_acc_nxt        = '0;
      time_bad_nxt        = 1'b0;
      saved_start_ms_nxt  = '0;
      saved_start_bad_nxt = 1'b0;
      arrow_match_nxt     = '0;
      pending_lf_nxt      = 1'b0;
    end

    if (res_cnt == 2'd2) res1.last_of_run = 1'b1;
    else                 res0.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= srtcp_pkg::PH_NUMBER;
      number_acc_r      <= '0;
      char_pos_r        <= '0;
      subfield_acc_r    <= '0;
      time_acc_r        <= '0;
      time_bad_r        <= 1'b0;
      saved_start_ms_r  <= '0;
      saved_start_bad_r <= 1'b0;
      arrow_match_r     <= '0;
      pending_lf_r      <= 1'b0;
      cues_done_r       <= '0;
    end else if (step) begin
      phase_r           <= phase_nxt;
      number_acc_r      <= number_acc_nxt;
      char_pos_r        <= char_pos_nxt;
      subfield_acc_r    <= subfield_acc_nxt;
      time_acc_r        <= time_acc_nxt;
      time_bad_r        <= time_bad_nxt;
      saved_start_ms_r  <= saved_start_ms_nxt;
      saved_start_bad_r <= saved_start_bad_nxt;
      arrow_match_r     <= arrow_match_nxt;
      pending_lf_r      <= pending_lf_nxt;
      cues_done_r       <= cues_done_nxt;
    end
  end

endmodule

>>> rtl/srt_cue_parser_core.sv
// ----------------------------------------------------------------------------
// srt_cue_parser_core
// streaming srt cue parser: cue number, start/end times in ms, text bytes
// ----------------------------------------------------------------------------
// The core takes srt text one byte per item and emits cue headers (number,
// start and end time in milliseconds with malformed flags), one text byte per
// result, and a cue-end result at the blank line that closes each cue. An
// input item is taken every cycle while the downstream side keeps up: each
// byte passes through an input register, one pass of parse logic and a
// three-entry result queue, and its results show on the out_ ports from the
// head of that queue. A byte that follows a held line break gives two
// results and so occupies the output for both of them; in_stall rises while
// a byte waits in the input register and the result queue holds two or more
// results. out_last_of_run marks the last result caused by an input byte.
// Asserting in_final_byte on the last byte of a file drops any unfinished
// cue and restarts at the number line; the count of completed cues
// (out_cue_index) keeps running.
// ----------------------------------------------------------------------------
module srt_cue_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_final_byte,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_cue_index,
  output logic [31:0] out_cue_number,
  output logic [28:0] out_start_ms,
  output logic [28:0] out_end_ms,
  output logic        out_start_bad,
  output logic        out_end_bad,
  output logic [7:0]  out_text_byte,
  output logic        out_last_of_run
);

  // input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] in_byte_r;
  logic       in_fin_r;
  logic       in_take;

  // parse pass
  logic               step;
  logic [1:0]         res_cnt;
  srtcp_pkg::result_t res0;
  srtcp_pkg::result_t res1;

  // result queue, head at entry 0
  srtcp_pkg::result_t q_r   [srtcp_pkg::QDEPTH];
  srtcp_pkg::result_t q_nxt [srtcp_pkg::QDEPTH];
  srtcp_pkg::result_t q_shift [srtcp_pkg::QDEPTH];
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic [1:0] q_base;
  logic       pop;

  // the parse step runs only when the queue has room for two results
  assign step     = in_v_r && (q_cnt_r <= 2'd1);
  assign in_stall = in_v_r && (q_cnt_r > 2'd1);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take)   in_v_nxt = 1'b1;
    else if (step) in_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_byte_value;
      in_fin_r  <= in_final_byte;
    end
  end

  srtcp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .byte_value (in_byte_r),
    .final_byte (in_fin_r),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  assign out_valid = (q_cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign q_base    = q_cnt_r - 2'(pop);

  always_comb begin
    q_shift[0] = pop ? q_r[1] : q_r[0];
    q_shift[1] = pop ? q_r[2] : q_r[1];
    q_shift[2] = q_r[2];
    for (int i = 0; i < srtcp_pkg::QDEPTH; i++) begin
      q_nxt[i] = q_shift[i];
      if (step && res_cnt != 2'd0 && q_base == 2'(i)) q_nxt[i] = res0;
      if (step && res_cnt == 2'd2 && (q_base + 2'd1) == 2'(i)) q_nxt[i] = res1;
    end
    q_cnt_nxt = q_base + (step ? res_cnt : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < srtcp_pkg::QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  assign out_kind        = q_r[0].kind;
  assign out_cue_index   = q_r[0].cue_index;
  assign out_cue_number  = q_r[0].cue_number;
  assign out_start_ms    = q_r[0].start_ms;
  assign out_end_ms      = q_r[0].end_ms;
  assign out_start_bad   = q_r[0].start_bad;
  assign out_end_bad     = q_r[0].end_bad;
  assign out_text_byte   = q_r[0].text_byte;
  assign out_last_of_run = q_r[0].last_of_run;

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result queue not empty after reset");

  // the second result of a pair is already queued behind the first
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |=> out_valid)
    else $error("first result of a pair without its partner");

  // only headers carry times and flags
  a_times_header_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != srtcp_pkg::KIND_HEADER |->
      out_start_ms == '0 && out_end_ms == '0 && !out_start_bad && !out_end_bad)
    else $error("time fields set on a non-header result");

  // only text results carry a byte
  a_text_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != srtcp_pkg::KIND_TEXT |-> out_text_byte == '0)
    else $error("text byte set on a non-text result");

  // a bad time always reads as zero
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_start_bad || out_end_bad) |->
      (!out_start_bad || out_start_ms == '0) && (!out_end_bad || out_end_ms == '0))
    else $error("malformed time with nonzero value");

endmodule
